### rtl/core/leadec_pkg.sv
// Shared types and codes for the LEA-128 block decrypt unit.
package leadec_pkg;

	localparam int WORD_W = 32;
	localparam int KEY_INDEX_W = 7;
	localparam int SLOT_W = 2;
	localparam int ROW_W = KEY_INDEX_W - SLOT_W;
	localparam int SLOTS = 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_RUN,
		ST_DONE
	} state_t;

	// Three dependent sub-steps of one round.
	typedef enum logic [1:0] {
		STEP_A,
		STEP_B,
		STEP_C
	} step_t;

	typedef struct packed {
		logic  key_we;
		logic  load_block;
		logic  run;
		step_t step;
		logic  out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic last_round;
	} dp_stat_t;

endpackage

### rtl/core/leadec_ram.sv
// Generic simple dual-port RAM with registered read data.
module leadec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 24,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/leadec_ctrl.sv
// Controller: sequences key loads, round steps and the output register.
module leadec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  leadec_pkg::dp_stat_t stat,
	output leadec_pkg::dp_cmd_t  dp_cmd
);
	import leadec_pkg::*;

	state_t state_q, state_d;
	step_t  step_q, step_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_DECRYPT) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (step_q == STEP_C && stat.last_round) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		step_d = step_q;
		if (state_q == ST_RUN) begin
			case (step_q)
				STEP_A: step_d = STEP_B;
				STEP_B: step_d = STEP_C;
				default: step_d = STEP_A;
			endcase
		end else begin
			step_d = STEP_A;
		end
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		dp_cmd.key_we = accept && cmd == CMD_LOAD;
		dp_cmd.load_block = accept && cmd == CMD_DECRYPT;
		dp_cmd.run = (state_q == ST_RUN);
		dp_cmd.step = step_q;
		dp_cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_A;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/leadec_dpath.sv
// Datapath: round-key store, block words, round counter and output register.
module leadec_dpath #(
	parameter int ROUNDS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  leadec_pkg::dp_cmd_t                 dp_cmd,
	output leadec_pkg::dp_stat_t                stat,
	input  logic [leadec_pkg::KEY_INDEX_W-1:0]  key_index,
	input  logic [leadec_pkg::WORD_W-1:0]       key_word,
	input  logic [leadec_pkg::WORD_W-1:0]       in_word0,
	input  logic [leadec_pkg::WORD_W-1:0]       in_word1,
	input  logic [leadec_pkg::WORD_W-1:0]       in_word2,
	input  logic [leadec_pkg::WORD_W-1:0]       in_word3,
	output logic [leadec_pkg::WORD_W-1:0]       out_word0,
	output logic [leadec_pkg::WORD_W-1:0]       out_word1,
	output logic [leadec_pkg::WORD_W-1:0]       out_word2,
	output logic [leadec_pkg::WORD_W-1:0]       out_word3
);
	import leadec_pkg::*;

	localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [RW-1:0] LAST_ROW = RW'(ROUNDS - 1);
	localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(ROUNDS);

	logic [WORD_W-1:0] x_q [SLOTS];
	logic [WORD_W-1:0] out_q [SLOTS];
	logic [WORD_W-1:0] k [SLOTS];
	logic [RW-1:0]     round_q;
	logic [RW-1:0]     rd_row;
	logic [ROW_W-1:0]  wr_row;
	logic [SLOT_W-1:0] wr_slot;
	logic              wr_in_range;
	logic [WORD_W-1:0] opnd;
	logic [WORD_W-1:0] prev;
	logic [WORD_W-1:0] kx;
	logic [WORD_W-1:0] res;
	logic              round_end;

	assign wr_row = key_index[KEY_INDEX_W-1:SLOT_W];
	assign wr_slot = key_index[SLOT_W-1:0];
	// Drop loads that land past the last round.
	assign wr_in_range = {1'b0, wr_row} < ROW_LIMIT;
	assign round_end = dp_cmd.run && dp_cmd.step == STEP_C;
	// Fetch the next round's keys during the last step of this one.
	assign rd_row = round_end ? round_q - 1'b1 : round_q;

	for (genvar g = 0; g < SLOTS; g++) begin : g_key
		leadec_ram #(
			.WIDTH(WORD_W),
			.DEPTH(ROUNDS),
			.AW   (RW)
		) u_key_ram (
			.clk    (clk),
			.we     (dp_cmd.key_we && wr_in_range && wr_slot == SLOT_W'(g)),
			.wr_addr(wr_row[RW-1:0]),
			.wr_data(key_word),
			.rd_addr(rd_row),
			.rd_data(k[g])
		);
	end

	always_comb begin
		case (dp_cmd.step)
			STEP_A: begin
				opnd = {x_q[0][8:0], x_q[0][WORD_W-1:9]};
				prev = x_q[3];
				kx = k[0];
			end
			STEP_B: begin
				opnd = {x_q[1][WORD_W-6:0], x_q[1][WORD_W-1:WORD_W-5]};
				prev = x_q[0];
				kx = k[2];
			end
			STEP_C: begin
				opnd = {x_q[2][WORD_W-4:0], x_q[2][WORD_W-1:WORD_W-3]};
				prev = x_q[1];
				kx = k[3];
			end
			default: begin
				opnd = x_q[0];
				prev = x_q[3];
				kx = k[0];
			end
		endcase
		res = (opnd - (prev ^ kx)) ^ k[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (dp_cmd.load_block) begin
			round_q <= LAST_ROW;
		end else if (round_end) begin
			round_q <= round_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_block) begin
			x_q[0] <= in_word0;
			x_q[1] <= in_word1;
			x_q[2] <= in_word2;
			x_q[3] <= in_word3;
		end else if (dp_cmd.run) begin
			case (dp_cmd.step)
				STEP_A: x_q[0] <= res;
				STEP_B: x_q[1] <= res;
				default: begin
					x_q[0] <= x_q[3];
					x_q[1] <= x_q[0];
					x_q[2] <= x_q[1];
					x_q[3] <= res;
				end
			endcase
		end
		if (dp_cmd.out_load) begin
			out_q <= x_q;
		end
	end

	assign stat.last_round = (round_q == '0);
	assign out_word0 = out_q[0];
	assign out_word1 = out_q[1];
	assign out_word2 = out_q[2];
	assign out_word3 = out_q[3];

endmodule

### rtl/core/lea128_block_decrypt_unit.sv
// Top level of the LEA-128 block decrypt unit.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | cmd, key_index, key_word, in_word0..in_word3
//  out     | out_valid / out_ready| out_word0..out_word3
//
// A key load writes one word of four per-slot key RAMs.
// A decrypt runs from accept through one key fetch state, one subtract step
// per cycle (three per round) on a shared 32-bit subtractor, and a load into
// the output register, which waits while an earlier result is still pending.
// in_ready is high whenever the controller is idle, also while a result waits.
// Reset clears control state only; the key store is undefined until loaded.
module lea128_block_decrypt_unit #(
	parameter int ROUNDS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [leadec_pkg::KEY_INDEX_W-1:0]  key_index,
	input  logic [leadec_pkg::WORD_W-1:0]       key_word,
	input  logic [leadec_pkg::WORD_W-1:0]       in_word0,
	input  logic [leadec_pkg::WORD_W-1:0]       in_word1,
	input  logic [leadec_pkg::WORD_W-1:0]       in_word2,
	input  logic [leadec_pkg::WORD_W-1:0]       in_word3,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [leadec_pkg::WORD_W-1:0]       out_word0,
	output logic [leadec_pkg::WORD_W-1:0]       out_word1,
	output logic [leadec_pkg::WORD_W-1:0]       out_word2,
	output logic [leadec_pkg::WORD_W-1:0]       out_word3
);
	import leadec_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t stat;

	leadec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.dp_cmd   (dp_cmd)
	);

	leadec_dpath #(
		.ROUNDS(ROUNDS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.dp_cmd   (dp_cmd),
		.stat     (stat),
		.key_index(key_index),
		.key_word (key_word),
		.in_word0 (in_word0),
		.in_word1 (in_word1),
		.in_word2 (in_word2),
		.in_word3 (in_word3),
		.out_word0(out_word0),
		.out_word1(out_word1),
		.out_word2(out_word2),
		.out_word3(out_word3)
	);

	// A decrypt item blocks the input until its rounds are done.
	a_decrypt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_DECRYPT |=> !in_ready)
		else $error("input ready right after a decrypt item was accepted");

	// A load item never produces a result.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_LOAD && !out_valid && !dp_cmd.out_load
		|=> !out_valid)
		else $error("result appeared after a key load item");

	// Never overwrite a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> (!out_valid || out_ready))
		else $error("output register loaded while a result is pending");

endmodule

### sim/lea128_block_decrypt_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LEA-128 block decrypt unit: key loads, decrypts, scoreboard.
module lea128_block_decrypt_unit_test;
	import leadec_pkg::*;

	localparam int ROUNDS = 24;
	localparam int KEY_WORDS = SLOTS * ROUNDS;
	localparam int COUNTED_ITEMS = 2000;
	localparam int SETTLE_CYCLES = 3 * ROUNDS + 40;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic                   hold_for_drain;
		logic                   cmd;
		logic [KEY_INDEX_W-1:0] key_index;
		word_t                  key_word;
		word_t                  w0, w1, w2, w3;
	} cipher_item_t;

	typedef struct packed {
		word_t w0, w1, w2, w3;
	} text_block_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   cmd;
	logic [KEY_INDEX_W-1:0] key_index;
	word_t                  key_word;
	word_t                  in_word0, in_word1, in_word2, in_word3;
	logic                   out_valid;
	logic                   out_ready;
	word_t                  out_word0, out_word1, out_word2, out_word3;

	word_t        round_keys [KEY_WORDS];
	cipher_item_t pending_items[$];
	text_block_t  plaintext_q[$];
	cipher_item_t on_bus;
	int unsigned  accepted_count = 0;
	int unsigned  total_items = 1;
	int unsigned  mismatch_count = 0;

	lea128_block_decrypt_unit #(
		.ROUNDS(ROUNDS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.key_index(key_index),
		.key_word (key_word),
		.in_word0 (in_word0),
		.in_word1 (in_word1),
		.in_word2 (in_word2),
		.in_word3 (in_word3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word0(out_word0),
		.out_word1(out_word1),
		.out_word2(out_word2),
		.out_word3(out_word3)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic word_t rotate_left(word_t v, int s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

	// Rounds run from the last one down to round 0.
	function automatic text_block_t decrypt_block(cipher_item_t it);
		word_t       x0, x1, x2, x3, t, k0, k1, k2, k3;
		text_block_t res;
		x0 = it.w0;
		x1 = it.w1;
		x2 = it.w2;
		x3 = it.w3;
		for (int r = ROUNDS - 1; r >= 0; r--) begin
			k0 = round_keys[SLOTS * r];
			k1 = round_keys[SLOTS * r + 1];
			k2 = round_keys[SLOTS * r + 2];
			k3 = round_keys[SLOTS * r + 3];
			x0 = (rotate_left(x0, WORD_W - 9) - (x3 ^ k0)) ^ k1;
			x1 = (rotate_left(x1, 5) - (x0 ^ k2)) ^ k1;
			x2 = (rotate_left(x2, 3) - (x1 ^ k3)) ^ k1;
			t = x3;
			x3 = x2;
			x2 = x1;
			x1 = x0;
			x0 = t;
		end
		res.w0 = x0;
		res.w1 = x1;
		res.w2 = x2;
		res.w3 = x3;
		return res;
	endfunction

	// Update the key copy on a load, queue the plaintext on a decrypt.
	task automatic absorb_item(cipher_item_t it);
		if (it.cmd == CMD_LOAD) begin
			if (it.key_index < KEY_WORDS)
				round_keys[it.key_index] = it.key_word;
		end else begin
			plaintext_q.push_back(decrypt_block(it));
		end
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic cipher_item_t make_load(int idx, word_t w);
		cipher_item_t it;
		it.hold_for_drain = 1'b0;
		it.cmd = CMD_LOAD;
		it.key_index = KEY_INDEX_W'(idx);
		it.key_word = w;
		it.w0 = $urandom;
		it.w1 = $urandom;
		it.w2 = $urandom;
		it.w3 = $urandom;
		return it;
	endfunction

	function automatic cipher_item_t make_decrypt(word_t a, word_t b, word_t c, word_t d);
		cipher_item_t it;
		it.hold_for_drain = 1'b0;
		it.cmd = CMD_DECRYPT;
		it.key_index = KEY_INDEX_W'($urandom);
		it.key_word = $urandom;
		it.w0 = a;
		it.w1 = b;
		it.w2 = c;
		it.w3 = d;
		return it;
	endfunction

	// Thirds of the run: receiver idles more, then sender idles more, then nobody idles.
	function automatic int sender_idle_pct();
		case (accepted_count * 3 / total_items)
			0: return 23;
			1: return 47;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (accepted_count * 3 / total_items)
			0: return 47;
			1: return 23;
			default: return 0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_proc
		cipher_item_t nxt;
		logic         free;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_LOAD;
			key_index <= '0;
			key_word <= '0;
			in_word0 <= '0;
			in_word1 <= '0;
			in_word2 <= '0;
			in_word3 <= '0;
		end else begin
			free = !in_valid;
			if (in_valid && in_ready) begin
				absorb_item(on_bus);
				accepted_count++;
				free = 1'b1;
			end
			if (free) begin
				// Hold a marked item until every plaintext is back.
				if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct()
				    && !(pending_items[0].hold_for_drain && plaintext_q.size() > 0)) begin
					nxt = pending_items.pop_front();
					on_bus = nxt;
					in_valid <= 1'b1;
					cmd <= nxt.cmd;
					key_index <= nxt.key_index;
					key_word <= nxt.key_word;
					in_word0 <= nxt.w0;
					in_word1 <= nxt.w1;
					in_word2 <= nxt.w2;
					in_word3 <= nxt.w3;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_proc
		text_block_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (plaintext_q.size() == 0) begin
					$display("%0t: unexpected plaintext %h %h %h %h", $time,
						out_word0, out_word1, out_word2, out_word3);
					mismatch_count++;
				end else begin
					want = plaintext_q.pop_front();
					if (out_word0 !== want.w0) begin
						$display("%0t: out_word0 expected %h actual %h", $time, want.w0, out_word0);
						mismatch_count++;
					end
					if (out_word1 !== want.w1) begin
						$display("%0t: out_word1 expected %h actual %h", $time, want.w1, out_word1);
						mismatch_count++;
					end
					if (out_word2 !== want.w2) begin
						$display("%0t: out_word2 expected %h actual %h", $time, want.w2, out_word2);
						mismatch_count++;
					end
					if (out_word3 !== want.w3) begin
						$display("%0t: out_word3 expected %h actual %h", $time, want.w3, out_word3);
						mismatch_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	initial begin : stimulus_proc
		cipher_item_t it;
		int unsigned  counted;
		arst_n = 1'b0;

		// Fill the whole key store before any decrypt.
		for (int i = 0; i < KEY_WORDS; i++) begin
			case (i)
				0: pending_items.push_back(make_load(i, '0));
				1: pending_items.push_back(make_load(i, '1));
				default: pending_items.push_back(make_load(i, $urandom));
			endcase
		end
		pending_items.push_back(make_decrypt('0, '0, '0, '0));
		pending_items.push_back(make_decrypt('1, '1, '1, '1));
		pending_items.push_back(make_decrypt(32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555));
		pending_items.push_back(make_decrypt(32'h8000_0000, 32'h0000_0001,
			32'h0000_0100, 32'h0080_0000));
		// Out-of-range loads must leave the store untouched.
		pending_items.push_back(make_load(KEY_WORDS, $urandom));
		pending_items.push_back(make_load(2 ** KEY_INDEX_W - 1, '1));
		pending_items.push_back(make_decrypt('0, '0, '0, '0));
		pending_items.push_back(make_load(KEY_WORDS - 1, '1));
		pending_items.push_back(make_load(5, '0));
		it = make_decrypt(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
		it.hold_for_drain = 1'b1;
		pending_items.push_back(it);
		pending_items.push_back(make_decrypt('1, '0, '1, '0));

		counted = 0;
		while (counted < COUNTED_ITEMS) begin
			if ($urandom_range(99) < 78) begin
				it = make_decrypt(pick_word(), pick_word(), pick_word(), pick_word());
				counted++;
			end else if ($urandom_range(99) < 15) begin
				it = make_load($urandom_range(2 ** KEY_INDEX_W - 1, KEY_WORDS), $urandom);
			end else begin
				it = make_load($urandom_range(KEY_WORDS - 1), pick_word());
				counted++;
			end
			if (counted % 250 == 0)
				it.hold_for_drain = 1'b1;
			pending_items.push_back(it);
		end
		total_items = pending_items.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || in_valid) @(negedge clk);
		while (plaintext_q.size() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("[lea128_block_decrypt_unit] OK");
		else
			$display("[lea128_block_decrypt_unit] ERROR");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout with %0d plaintexts outstanding", plaintext_q.size());
		$display("[lea128_block_decrypt_unit] ERROR");
		$finish;
	end

endmodule
